// ----- src/ple_pkg.sv -----
`timescale 1ns / 1ps
package ple_pkg;

  localparam int DATA_W     = 32;
  localparam int ACTION_W   = 3;
  localparam int POS_W      = 8;
  localparam int OUT_CNT_W  = 7;
  localparam int CAPACITY_D = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // what every cell of the row does on a clock edge
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } list_op_e;

endpackage

// ----- src/ple_cell.sv -----
`timescale 1ns / 1ps
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic              clk_i,
  input  list_op_e          op_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      OP_INSERT: begin
        if (MyIdx == idx_i) begin
          data_d = value_i;
        end else if (MyIdx > idx_i) begin
          data_d = left_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= idx_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // contents stay undefined until written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- src/ple_ctrl.sv -----
`timescale 1ns / 1ps
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_D,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                valid_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [CNT_W-1:0]    count_i,
  output list_op_e            op_o,
  output logic [IDX_W-1:0]    idx_o,
  output status_e             status_o,
  output logic [CNT_W-1:0]    count_o
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [CMP_W-1:0] pos_c, cnt_c;
  logic             full, empty;
  list_op_e         op;

  assign pos_c = CMP_W'(position_i);
  assign cnt_c = CMP_W'(count_i);
  assign full  = (count_i == CapCnt);
  assign empty = (count_i == '0);

  always_comb begin
    op       = OP_HOLD;
    idx_o    = '0;
    status_o = ST_OK;
    unique case (action_i)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
        priority if (full) begin
          status_o = ST_FULL;
        end else if (action_i == ACT_INS_FRONT) begin
          op = OP_INSERT;
        end else if (action_i == ACT_INS_BACK) begin
          op    = OP_INSERT;
          idx_o = IDX_W'(count_i);
        end else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
          status_o = ST_BADPOS;
        end else begin
          op    = OP_INSERT;
          idx_o = IDX_W'(pos_c - CMP_W'(1));
        end
      end
      ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
        priority if (empty) begin
          status_o = ST_EMPTY;
        end else if (action_i == ACT_DEL_FRONT) begin
          op = OP_DELETE;
        end else if (action_i == ACT_DEL_BACK) begin
          op    = OP_DELETE;
          idx_o = IDX_W'(count_i - CNT_W'(1));
        end else if (pos_c == '0 || pos_c > cnt_c) begin
          status_o = ST_BADPOS;
        end else begin
          op    = OP_DELETE;
          idx_o = IDX_W'(pos_c - CMP_W'(1));
        end
      end
      default: status_o = ST_BADPOS;
    endcase
  end

  assign op_o = valid_i ? op : OP_HOLD;

  always_comb begin
    unique case (op_o)
      OP_INSERT: count_o = count_i + CNT_W'(1);
      OP_DELETE: count_o = count_i - CNT_W'(1);
      default:   count_o = count_i;
    endcase
  end

endmodule

// ----- src/positional_list_engine.sv -----
`timescale 1ns / 1ps
// ordered list of up to CAPACITY signed 32-bit words, front at position 1
// command channel: a word (action_i, value_i, position_i) is taken at a rising
//   edge with start_i high and busy_o low; busy_o stays low, so a new command
//   may follow in every cycle
// result channel: done_o is high for exactly one cycle, in the cycle after the
//   command is taken, with status_o and element_count_o (count after the op)
// throughput: one command per cycle; every cell of the row loads, shifts in
//   from a neighbor or holds in the same edge, so inserts and deletes at any
//   position keep that rate
// the receiver cannot stall: each result shows for its one cycle only
// reset: rst_ni (async, active low) empties the list and clears done_o;
//   the cell contents are not cleared, only entries below the count are used
// rejected commands (full, empty, bad position, unknown action) leave the
//   list unchanged and report the unchanged count
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [ACTION_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0]    value_i,
  input  logic [POS_W-1:0]            position_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [OUT_CNT_W-1:0]        element_count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 accept;
  list_op_e             op;
  logic [IDX_W-1:0]     idx;
  status_e              status_d, status_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic                 done_q;
  logic [DATA_W-1:0]    value_u;
  logic [DATA_W-1:0]    cell_data [CAPACITY];

  assign busy_o  = 1'b0;
  assign accept  = start_i & ~busy_o;
  assign value_u = DATA_W'(value_i);

  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .valid_i    (accept),
    .action_i   (action_i),
    .position_i (position_i),
    .count_i    (count_q),
    .op_o       (op),
    .idx_o      (idx),
    .status_o   (status_d),
    .count_o    (count_d)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    // end cells feed back their own word; the first cell never selects it, the last only on a delete, beyond the count
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    ple_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .idx_i   (idx),
      .value_i (value_u),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_cnt_q <= OUT_CNT_W'(count_d);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign element_count_o = out_cnt_q;

endmodule

// ----- src/ple_checker.sv -----
`timescale 1ns / 1ps
module ple_checker
  import ple_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 done_o,
  input logic [1:0]           status_o,
  input logic [OUT_CNT_W-1:0] element_count_o
);

  // last count reported on the result channel
  logic [OUT_CNT_W-1:0] last_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (done_o) begin
      last_cnt_q <= element_count_o;
    end
  end

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without a command");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> element_count_o == last_cnt_q)
    else $error("rejected command changed the count");

  a_ok_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OK) |->
      (element_count_o == last_cnt_q + 7'd1 || element_count_o == last_cnt_q - 7'd1))
    else $error("accepted command moved the count by other than one");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> last_cnt_q == '0)
    else $error("empty reported on a non-empty list");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
